// ===== sv/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// Beep pattern sequencer package
// Shared types, action codes and the beep pattern ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    localparam int STEP_SLOTS_DEF  = 12;
    localparam int PULSE_LIMIT_DEF = 5;

    localparam int ROM_ROWS = 13;
    localparam int ROM_COLS = 12;
    localparam int MS_W     = 10;

    localparam logic [MS_W-1:0] PULSE_ON_MS  = 10'd70;
    localparam logic [MS_W-1:0] PULSE_OFF_MS = 10'd90;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_PLAY  = 2'd1;
    localparam logic [1:0] ACT_COUNT = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] pattern;
        logic [7:0] count;
    } t_cmd;

    typedef struct packed {
        logic buzzer_on;
        logic busy;
    } t_res;

    typedef struct packed {
        logic            level;
        logic [MS_W-1:0] ms;
    } t_step;

    function automatic logic [3:0] rom_len(input logic [3:0] pat);
        logic [3:0] n;
        begin
            case (pat)
                4'd1, 4'd2, 4'd4, 4'd6, 4'd11, 4'd12: n = 4'd1;
                4'd3:                                n = 4'd2;
                4'd5, 4'd10:                         n = 4'd3;
                4'd7:                                n = 4'd5;
                4'd8, 4'd9:                          n = 4'd7;
                default:                             n = 4'd0;
            endcase
            return n;
        end
    endfunction

    function automatic t_step rom_step(input logic [3:0] pat, input logic [3:0] idx);
        t_step s;
        begin
            s.level = 1'b1;
            s.ms    = '0;
            case (pat)
                4'd1:  s.ms = 10'd80;
                4'd2:  s.ms = 10'd200;
                4'd3: begin
                    s.level = ~idx[0];
                    s.ms    = idx[0] ? 10'd90 : 10'd70;
                end
                4'd4:  s.ms = 10'd40;
                4'd5: begin
                    case (idx)
                        4'd0:    s.ms = 10'd60;
                        4'd1: begin
                            s.level = 1'b0;
                            s.ms    = 10'd80;
                        end
                        default: s.ms = 10'd100;
                    endcase
                end
                4'd6:  s.ms = 10'd500;
                4'd7: begin
                    s.level = ~idx[0];
                    s.ms    = 10'd80;
                end
                4'd8: begin
                    if (idx < 4'd6) begin
                        s.level = ~idx[0];
                        s.ms    = idx[0] ? 10'd150 : 10'd250;
                    end else begin
                        s.ms = 10'd400;
                    end
                end
                4'd9: begin
                    if (idx < 4'd6) begin
                        s.level = ~idx[0];
                        s.ms    = 10'd60;
                    end else begin
                        s.ms = 10'd90;
                    end
                end
                4'd10: begin
                    case (idx)
                        4'd0:    s.ms = 10'd100;
                        4'd1: begin
                            s.level = 1'b0;
                            s.ms    = 10'd100;
                        end
                        default: s.ms = 10'd200;
                    endcase
                end
                4'd11: s.ms = 10'd1000;
                4'd12: s.ms = 10'd100;
                default: begin
                    s.level = 1'b0;
                    s.ms    = '0;
                end
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/bps_core.sv =====
// ----------------------------------------------------------------------------
// Beep pattern sequencer core
// Playback state and its single-pass update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_core #(
    parameter int STEP_SLOTS  = bps_pkg::STEP_SLOTS_DEF,
    parameter int PULSE_LIMIT = bps_pkg::PULSE_LIMIT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire bps_pkg::t_cmd i_cmd,
    output bps_pkg::t_res      o_res
);

    localparam int PULSE_CAP = (PULSE_LIMIT < STEP_SLOTS / 2) ? PULSE_LIMIT : STEP_SLOTS / 2;
    localparam int MS_W      = bps_pkg::MS_W;

    logic            r_playing,  n_playing;
    logic            r_count_mode, n_count_mode;
    logic [3:0]      r_psel,     n_psel;
    logic [3:0]      r_step,     n_step;
    logic [MS_W-1:0] r_ms,       n_ms;
    logic            r_tone,     n_tone;
    logic [3:0]      r_clen,     n_clen;

    logic            do_enter;
    logic [4:0]      e_idx;
    logic [4:0]      e_steps;
    logic [3:0]      tbl_len;
    logic [3:0]      pulses;
    bps_pkg::t_step  rom_q;

    always_comb begin
        n_playing    = r_playing;
        n_count_mode = r_count_mode;
        n_psel       = r_psel;
        n_step       = r_step;
        n_ms         = r_ms;
        n_tone       = r_tone;
        n_clen       = r_clen;
        do_enter     = 1'b0;
        e_idx        = '0;
        pulses       = (i_cmd.count > 8'(PULSE_CAP)) ? 4'(PULSE_CAP) : i_cmd.count[3:0];

        unique case (i_cmd.action)
            bps_pkg::ACT_TICK: begin
                if (r_playing) begin
                    if (r_ms > MS_W'(1)) begin
                        n_ms = r_ms - MS_W'(1);
                    end else begin
                        n_ms     = '0;
                        do_enter = 1'b1;
                        e_idx    = {1'b0, r_step} + 5'd1;
                    end
                end
            end
            bps_pkg::ACT_PLAY: begin
                if (i_cmd.pattern == 4'd0 || i_cmd.pattern >= 4'(bps_pkg::ROM_ROWS)) begin
                    n_playing = 1'b0;
                    n_tone    = 1'b0;
                end else begin
                    n_count_mode = 1'b0;
                    n_psel       = i_cmd.pattern;
                    n_playing    = 1'b1;
                    do_enter     = 1'b1;
                end
            end
            bps_pkg::ACT_COUNT: begin
                if (i_cmd.count == 8'd0) begin
                    n_playing = 1'b0;
                    n_tone    = 1'b0;
                end else begin
                    n_clen       = 4'(pulses << 1);
                    n_count_mode = 1'b1;
                    n_playing    = 1'b1;
                    do_enter     = 1'b1;
                end
            end
            default: begin
                n_playing = 1'b0;
                n_tone    = 1'b0;
            end
        endcase

        tbl_len = bps_pkg::rom_len(n_psel);
        if (n_count_mode) begin
            e_steps = {1'b0, n_clen};
        end else if ({1'b0, tbl_len} > 5'(STEP_SLOTS)) begin
            e_steps = 5'(STEP_SLOTS);
        end else begin
            e_steps = {1'b0, tbl_len};
        end
        rom_q = bps_pkg::rom_step(n_psel, e_idx[3:0]);

        if (do_enter) begin
            if (e_idx >= e_steps) begin
                n_playing = 1'b0;
                n_tone    = 1'b0;
            end else begin
                n_step = e_idx[3:0];
                if (n_count_mode) begin
                    n_tone = ~e_idx[0];
                    n_ms   = e_idx[0] ? bps_pkg::PULSE_OFF_MS : bps_pkg::PULSE_ON_MS;
                end else begin
                    n_tone = rom_q.level;
                    n_ms   = rom_q.ms;
                end
            end
        end
    end

    assign o_res.buzzer_on = n_tone;
    assign o_res.busy      = n_playing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing    <= 1'b0;
            r_count_mode <= 1'b0;
            r_psel       <= '0;
            r_step       <= '0;
            r_ms         <= '0;
            r_tone       <= 1'b0;
            r_clen       <= '0;
        end else if (i_fire) begin
            r_playing    <= n_playing;
            r_count_mode <= n_count_mode;
            r_psel       <= n_psel;
            r_step       <= n_step;
            r_ms         <= n_ms;
            r_tone       <= n_tone;
            r_clen       <= n_clen;
        end
    end

    a_tone_needs_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tone |-> r_playing)
        else $error("buzzer sounding while idle");

    a_ms_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> r_ms != '0)
        else $error("active step with no time left");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_playing && r_count_mode) |-> r_step < r_clen)
        else $error("count step past pattern end");

    a_table_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_playing && !r_count_mode) |->
            (r_psel != 4'd0 && r_psel < 4'(bps_pkg::ROM_ROWS)))
        else $error("table playback on null pattern");

endmodule

`default_nettype wire

// ===== sv/beep_pattern_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// Beep pattern sequencer unit
// Buzzer drive from a pattern ROM, one request per cycle while not stalled.
// ----------------------------------------------------------------------------
// Path: an accepted request goes to the input register, and its result to
// the result register, which drives the outputs.
// Throughput: one request per cycle while o_stall is low; the whole update is one pass of logic.
// Reset: synchronous; playback idle, both pipeline stages empty; result register not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module beep_pattern_sequencer_unit #(
    parameter int STEP_SLOTS  = bps_pkg::STEP_SLOTS_DEF,
    parameter int PULSE_LIMIT = bps_pkg::PULSE_LIMIT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_action,
    input  wire logic [3:0] i_pattern,
    input  wire logic [7:0] i_count,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_buzzer_on,
    output logic            o_busy_res
);

    logic          advance;
    logic          fire;
    logic          r_in_valid;
    logic          r_out_valid;
    bps_pkg::t_cmd r_cmd;
    bps_pkg::t_res r_res;
    bps_pkg::t_res core_res;

    assign advance = !(r_out_valid && i_stall);
    assign fire    = advance && r_in_valid;
    assign o_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid  <= i_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_cmd.action  <= i_action;
            r_cmd.pattern <= i_pattern;
            r_cmd.count   <= i_count;
        end
        if (fire) begin
            r_res <= core_res;
        end
    end

    bps_core #(
        .STEP_SLOTS  (STEP_SLOTS),
        .PULSE_LIMIT (PULSE_LIMIT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (r_cmd),
        .o_res   (core_res)
    );

    assign o_valid     = r_out_valid;
    assign o_buzzer_on = r_res.buzzer_on;
    assign o_busy_res  = r_res.busy;

endmodule

`default_nettype wire
